### rtl/mrr_pkg.sv
`default_nettype none

package mrr_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // reply layout, in transmit order
    localparam int REPLY_BYTES    = 7;
    localparam int REPLY_CRC_SPAN = 5;
    localparam logic [2:0] POS_ADDRESS  = 3'd0;
    localparam logic [2:0] POS_FUNCTION = 3'd1;
    localparam logic [2:0] POS_COUNT    = 3'd2;
    localparam logic [2:0] POS_VALUE_HI = 3'd3;
    localparam logic [2:0] POS_VALUE_LO = 3'd4;
    localparam logic [2:0] POS_CRC_LO   = 3'd5;
    localparam logic [2:0] POS_CRC_HI   = 3'd6;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_CODE       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLY_BYTE_COUNT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_REGISTER_CODE = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] function_code;
        logic [7:0] reply_byte_count;
        logic [7:0] first_register_code;
    } cfg_t;

    // one accepted read, value captured at the end of the request frame
    typedef struct packed {
        logic [15:0] value;
    } job_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/modbus_rtu_register_responder.sv
`default_nettype none
// reply path: the last byte of a good request queues a job, the back end loads its value,
//   then sends seven reply bytes, one per cycle unless m_tready stalls the output register
// throughput: one input item per cycle; s_tready drops only while the two-entry reply queue
//   is full, since each request byte runs through a combinational byte-wide crc
// reset: synchronous active-low aresetn restores the register defaults, clears all channel
//   values, request byte counter, reply queue and m_tvalid/m_tlast, presets the request crc

module modbus_rtu_register_responder
    import mrr_pkg::*;
#(
    parameter int FRAME_BYTES       = 8,
    parameter int FUNCTION_POSITION = 1,
    parameter int REGISTER_POSITION = 3,
    parameter int CHANNELS          = 7
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,   // request_byte [7:0], channel [10:8],
                                                   // sensor_value [26:11], zero [31:27]
    input  wire logic                   s_tuser,   // command [0]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // reply_byte [7:0]
    output logic                        m_tlast
);

    cfg_t cfg_reg;
    logic accept;
    logic push;
    job_t push_data;
    logic full;
    logic pop;
    job_t pop_data;
    logic empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_address       <= 8'd1;
            cfg_reg.function_code       <= 8'd3;
            cfg_reg.reply_byte_count    <= 8'd2;
            cfg_reg.first_register_code <= 8'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS:       cfg_reg.slave_address       <= cfg_wdata;
                REG_FUNCTION_CODE:       cfg_reg.function_code       <= cfg_wdata;
                REG_REPLY_BYTE_COUNT:    cfg_reg.reply_byte_count    <= cfg_wdata;
                REG_FIRST_REGISTER_CODE: cfg_reg.first_register_code <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    mrr_front #(
        .FRAME_BYTES       (FRAME_BYTES),
        .FUNCTION_POSITION (FUNCTION_POSITION),
        .REGISTER_POSITION (REGISTER_POSITION),
        .CHANNELS          (CHANNELS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .accept       (accept),
        .command      (s_tuser),
        .request_byte (s_tdata[7:0]),
        .channel      (s_tdata[10:8]),
        .sensor_value (s_tdata[26:11]),
        .push         (push),
        .push_data    (push_data)
    );

    mrr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    mrr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/mrr_fifo.sv
`default_nettype none

module mrr_fifo
    import mrr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_data,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_data,
    output logic      empty
);

    job_t       mem [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'(QUEUE_DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("pop from empty queue");

endmodule

`default_nettype wire

### rtl/mrr_front.sv
`default_nettype none

module mrr_front
    import mrr_pkg::*;
#(
    parameter int FRAME_BYTES       = 8,
    parameter int FUNCTION_POSITION = 1,
    parameter int REGISTER_POSITION = 3,
    parameter int CHANNELS          = 7
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  cfg_t             cfg,
    input  wire logic        accept,
    input  wire logic        command,
    input  wire logic [7:0]  request_byte,
    input  wire logic [2:0]  channel,
    input  wire logic [15:0] sensor_value,
    output logic             push,
    output job_t             push_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [15:0] chan_vals_reg [CHANNELS];
    logic [15:0] crc_reg;
    logic [3:0]  pos_reg;
    logic [7:0]  func_reg;
    logic [7:0]  regsel_reg;

    logic [15:0] crc_next;
    logic [7:0]  func_next;
    logic [7:0]  regsel_next;
    logic [3:0]  pos_inc;
    logic        frame_end;
    logic [7:0]  sel;
    logic        sel_ok;
    logic [7:0]  chan_ext;
    logic        chan_ok;

    always_comb begin
        crc_next    = crc_feed(crc_reg, request_byte);
        func_next   = (pos_reg == 4'(FUNCTION_POSITION)) ? request_byte : func_reg;
        regsel_next = (pos_reg == 4'(REGISTER_POSITION)) ? request_byte : regsel_reg;
        pos_inc     = pos_reg + 4'd1;
        frame_end   = (pos_inc == 4'(FRAME_BYTES));
        sel         = regsel_next - cfg.first_register_code;
        sel_ok      = (sel < 8'(CHANNELS));
        chan_ext    = {5'd0, channel};
        chan_ok     = (chan_ext < 8'(CHANNELS));
        push        = accept && !command && frame_end && (crc_next == 16'h0000)
                      && (func_next == cfg.function_code) && sel_ok;
        push_data.value = chan_vals_reg[sel[CH_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= CRC_INIT;
            pos_reg    <= 4'd0;
            func_reg   <= 8'd0;
            regsel_reg <= 8'd0;
            for (int i = 0; i < CHANNELS; i++) begin
                chan_vals_reg[i] <= 16'd0;
            end
        end else if (accept) begin
            if (command) begin
                if (chan_ok) begin
                    chan_vals_reg[chan_ext[CH_W-1:0]] <= sensor_value;
                end
            end else begin
                func_reg   <= func_next;
                regsel_reg <= regsel_next;
                if (frame_end) begin
                    crc_reg <= CRC_INIT;
                    pos_reg <= 4'd0;
                end else begin
                    crc_reg <= crc_next;
                    pos_reg <= pos_inc;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/mrr_back.sv
`default_nettype none

module mrr_back
    import mrr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  cfg_t            cfg,
    input  wire logic       empty,
    input  job_t            pop_data,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // reply_byte [7:0]
    output logic            m_tlast
);

    typedef enum logic {ST_IDLE, ST_SEND} state_t;

    state_t      state_reg;
    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic [15:0] value_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;

    logic        out_free;
    logic [7:0]  byte_sel;

    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        unique case (idx_reg)
            POS_ADDRESS:  byte_sel = cfg.slave_address;
            POS_FUNCTION: byte_sel = cfg.function_code;
            POS_COUNT:    byte_sel = cfg.reply_byte_count;
            POS_VALUE_HI: byte_sel = value_reg[15:8];
            POS_VALUE_LO: byte_sel = value_reg[7:0];
            POS_CRC_LO:   byte_sel = crc_reg[7:0];
            POS_CRC_HI:   byte_sel = crc_reg[15:8];
            default:      byte_sel = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= 3'd0;
            crc_reg      <= CRC_INIT;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            // while sending, the send arm below owns the valid flag
            if (m_tready && (state_reg != ST_SEND)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!empty) begin
                        value_reg <= pop_data.value;
                        idx_reg   <= 3'd0;
                        crc_reg   <= CRC_INIT;
                        state_reg <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= byte_sel;
                        m_tlast_reg  <= (idx_reg == POS_CRC_HI);
                        // reply crc covers the header and value bytes only
                        if (idx_reg < 3'(REPLY_CRC_SPAN)) begin
                            crc_reg <= crc_feed(crc_reg, byte_sel);
                        end
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == POS_CRC_HI) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND) |-> (idx_reg < 3'(REPLY_BYTES)))
        else $error("reply index out of range");

endmodule

`default_nettype wire

### tb/tb.sv
module tb;
    import mrr_pkg::*;

    localparam int FRAME_LEN     = 8;
    localparam int FUNC_POS      = 1;
    localparam int REG_POS       = 3;
    localparam int CHAN_COUNT    = 7;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 60;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_byte_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   m_tlast;

    // predicted responder state
    logic [7:0]  cur_address;
    logic [7:0]  cur_function;
    logic [7:0]  cur_count;
    logic [7:0]  cur_base;
    logic [15:0] chan_reading [CHAN_COUNT];
    logic [15:0] rx_crc;
    int          rx_pos;
    logic [7:0]  rx_function;
    logic [7:0]  rx_register;

    reply_byte_t reply_queue [$];

    int  mismatches     = 0;
    int  items_sent     = 0;
    int  bytes_checked  = 0;
    int  frames_replied = 0;
    int  idle_cycles    = 0;
    int  ready_left     = 0;
    bit  calm           = 1'b0;

    modbus_rtu_register_responder #(
        .FRAME_BYTES      (FRAME_LEN),
        .FUNCTION_POSITION(FUNC_POS),
        .REGISTER_POSITION(REG_POS),
        .CHANNELS         (CHAN_COUNT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // data bits enter at the lsb, one per shift
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ data[k];
            c = {1'b0, c[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void predict_item(input logic cmd, input logic [7:0] rx,
                                         input logic [2:0] ch, input logic [15:0] val);
        logic [7:0]  reply [REPLY_BYTES];
        logic [7:0]  sel;
        logic [15:0] c;
        bit          good;
        if (cmd) begin
            if (ch < CHAN_COUNT) chan_reading[ch] = val;
            return;
        end
        if (rx_pos == FUNC_POS) rx_function = rx;
        if (rx_pos == REG_POS) rx_register = rx;
        rx_crc = crc16_step(rx_crc, rx);
        rx_pos = (rx_pos + 1) % 16;
        if (rx_pos < FRAME_LEN) return;
        good = (rx_crc == 16'h0000) && (rx_function == cur_function);
        rx_crc = CRC_INIT;
        rx_pos = 0;
        if (!good) return;
        sel = rx_register - cur_base;
        if (sel >= CHAN_COUNT) return;
        reply[POS_ADDRESS]  = cur_address;
        reply[POS_FUNCTION] = cur_function;
        reply[POS_COUNT]    = cur_count;
        reply[POS_VALUE_HI] = chan_reading[sel][15:8];
        reply[POS_VALUE_LO] = chan_reading[sel][7:0];
        c = CRC_INIT;
        for (int k = 0; k < REPLY_CRC_SPAN; k++) c = crc16_step(c, reply[k]);
        reply[POS_CRC_LO] = c[7:0];
        reply[POS_CRC_HI] = c[15:8];
        for (int k = 0; k < REPLY_BYTES; k++)
            reply_queue.push_back('{data: reply[k], last: (k == REPLY_BYTES - 1)});
        frames_replied++;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        reply_byte_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (reply_queue.size() == 0) begin
                report_mismatch($sformatf("reply byte %02h with none expected", m_tdata));
            end else begin
                want = reply_queue.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("reply byte %02h, expected %02h",
                                              m_tdata, want.data));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
            end
            bytes_checked++;
        end
    end

    // receiver stalls in bursts until the calm tail
    always @(negedge aclk) begin
        if (calm) begin
            m_tready = 1'b1;
        end else if (ready_left == 0) begin
            m_tready = ($urandom_range(0, 2) != 0);
            ready_left = $urandom_range(1, 19);
        end else begin
            ready_left--;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reset_dut();
        cur_address  = 8'd1;
        cur_function = 8'd3;
        cur_count    = 8'd2;
        cur_base     = 8'd0;
        for (int k = 0; k < CHAN_COUNT; k++) chan_reading[k] = 16'h0000;
        rx_crc      = CRC_INIT;
        rx_pos      = 0;
        rx_function = 8'h00;
        rx_register = 8'h00;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    endtask

    // called just after a falling edge; valid stays high when the next transfer follows
    task automatic send_item(input logic cmd, input logic [7:0] rx,
                             input logic [2:0] ch, input logic [15:0] val);
        s_tuser  = cmd;
        s_tdata  = {5'b00000, val, ch, rx};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_item(cmd, rx, ch, val);
        items_sent++;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(1'b0, rx, 3'($urandom_range(0, 7)), 16'($urandom));
    endtask

    task automatic send_update(input logic [2:0] ch, input logic [15:0] val);
        send_item(1'b1, 8'($urandom), ch, val);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [7:0] func, input logic [7:0] reg_code,
                                input bit bad_crc, input bit mix);
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] c;
        for (int k = 0; k < FRAME_LEN; k++) frame[k] = 8'($urandom);
        frame[FUNC_POS] = func;
        frame[REG_POS]  = reg_code;
        c = CRC_INIT;
        for (int k = 0; k < FRAME_LEN - 2; k++) c = crc16_step(c, frame[k]);
        frame[FRAME_LEN-2] = c[7:0];
        frame[FRAME_LEN-1] = c[15:8];
        // a single flipped bit always breaks the crc
        if (bad_crc)
            frame[$urandom_range(0, FRAME_LEN - 1)] ^= 8'h01 << $urandom_range(0, 7);
        for (int k = 0; k < FRAME_LEN; k++) begin
            if (mix && $urandom_range(0, 5) == 0)
                send_update(3'($urandom_range(0, 7)), pick_value());
            send_byte(frame[k]);
        end
    endtask

    // random bytes, then padding until the frame counter wraps
    task automatic send_noise();
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
        while (rx_pos != 0) send_byte(8'($urandom));
    endtask

    task automatic wait_quiet();
        s_tvalid = 1'b0;
        while (reply_queue.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        s_tvalid  = 1'b0;
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge aclk);
        case (idx)
            REG_SLAVE_ADDRESS:       cur_address  = val;
            REG_FUNCTION_CODE:       cur_function = val;
            REG_REPLY_BYTE_COUNT:    cur_count    = val;
            REG_FIRST_REGISTER_CODE: cur_base     = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input logic [7:0] address, input logic [7:0] func,
                              input logic [7:0] count, input logic [7:0] base);
        wait_quiet();
        write_reg(REG_SLAVE_ADDRESS, address);
        write_reg(REG_FUNCTION_CODE, func);
        write_reg(REG_REPLY_BYTE_COUNT, count);
        write_reg(REG_FIRST_REGISTER_CODE, base);
    endtask

    task automatic test_reset_state();
        send_request(cur_function, 8'd0, 1'b0, 1'b0);
        send_request(cur_function, 8'd7, 1'b0, 1'b0);
    endtask

    task automatic test_directed_frames();
        send_update(3'd0, 16'hFFFF);
        send_update(3'd7, 16'h5A5A);
        send_update(3'd6, 16'h8001);
        send_request(cur_function, 8'd0, 1'b0, 1'b0);
        send_request(cur_function ^ 8'h80, 8'd6, 1'b0, 1'b0);
        send_request(cur_function, 8'd6, 1'b1, 1'b0);
    endtask

    task automatic test_register_window();
        set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(8'hFF, 8'hFF, 1'b0, 1'b0);
        // base near the top wraps the channel window past zero
        send_request(8'hFF, 8'h05, 1'b0, 1'b0);
        send_request(8'hFF, 8'h06, 1'b0, 1'b0);
        send_request(8'hFF, 8'hFE, 1'b0, 1'b0);
        set_config(8'h00, 8'h00, 8'h00, 8'h00);
        send_request(8'h00, 8'h00, 1'b0, 1'b0);
        send_request(8'h00, 8'h06, 1'b0, 1'b0);
        send_request(8'h00, 8'h07, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int phase_start;
        int pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            calm = (phase == RANDOM_PHASES - 1);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 19);
                if (pick < 11)
                    send_request(cur_function, cur_base + 8'($urandom_range(0, CHAN_COUNT - 1)),
                                 1'b0, 1'b1);
                else if (pick < 13)
                    send_request(cur_function, 8'($urandom), 1'b0, 1'b1);
                else if (pick < 15)
                    send_request(cur_function, cur_base + 8'($urandom_range(0, CHAN_COUNT - 1)),
                                 1'b1, 1'b1);
                else if (pick < 17)
                    send_request(cur_function ^ (8'h01 << $urandom_range(0, 7)),
                                 cur_base + 8'($urandom_range(0, CHAN_COUNT - 1)), 1'b0, 1'b1);
                else if (pick < 19)
                    send_update(3'($urandom_range(0, 7)), pick_value());
                else
                    send_noise();
                if (!calm && $urandom_range(0, 15) == 0) wait_quiet();
            end
        end
    endtask

    initial begin
        reset_dut();
        test_reset_state();
        test_directed_frames();
        test_register_window();
        test_random_traffic();
        s_tvalid = 1'b0;
        while (reply_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("sent %0d input transfers: request frames, sensor updates and noise",
                 items_sent);
        $display("checked %0d reply bytes from %0d answered frames over %0d settings",
                 bytes_checked, frames_replied, RANDOM_PHASES + 3);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
